[rtl/tdema_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdema_pkg
// shared widths, register indexes and reset values for the thermistor
// divider resistance filter
// ----------------------------------------------------------------------------
package tdema_pkg;

  localparam int CHANNEL_W   = 1;
  localparam int SAMPLE_W    = 12;
  localparam int REF_W       = 20;
  localparam int ALPHA_W     = 17;
  localparam int RES_W       = 40;
  localparam int AVG_W       = 41;
  localparam int FRAC_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;
  localparam int DEF_CHANNELS = 2;

  localparam int DIGIT_W     = 4;
  localparam int PROD_W      = REF_W + SAMPLE_W;
  localparam int MUL_STEPS   = SAMPLE_W / DIGIT_W;
  localparam int DIV_STEPS   = PROD_W + FRAC_W;
  localparam int APAD_W      = 20;
  localparam int EMA_STEPS   = APAD_W / DIGIT_W;
  localparam int DIFF_W      = AVG_W + 1;
  localparam int ACC_W       = DIFF_W + APAD_W;
  localparam int CNT_W       = 6;

  localparam logic [SAMPLE_W-1:0]   FULL_SCALE  = 12'd4095;
  localparam logic [ALPHA_W-1:0]    WEIGHT_ONE  = 17'd65536;
  localparam logic [REF_W-1:0]      REF_RESET   = 20'd30000;
  localparam logic [ALPHA_W-1:0]    ALPHA_RESET = 17'd6554;

  localparam logic [CFG_IDX_W-1:0]  REG_REFERENCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_SMOOTHING = 1'd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMA  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

[rtl/tdema_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdema_in_if
// sample channel: valid/ready handshake with channel number and adc reading
// ----------------------------------------------------------------------------
interface tdema_in_if;
  logic                              valid;
  logic                              ready;
  logic [tdema_pkg::CHANNEL_W-1:0]   channel;
  logic [tdema_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface
`default_nettype wire

[rtl/tdema_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdema_out_if
// result channel: valid/ready handshake with filtered resistance and flag
// ----------------------------------------------------------------------------
interface tdema_out_if;
  logic                           valid;
  logic                           ready;
  logic [tdema_pkg::RES_W-1:0]    filtered_resistance;
  logic                           updated;

  modport source (output valid, output filtered_resistance, output updated, input ready);
  modport sink   (input valid, input filtered_resistance, input updated, output ready);
endinterface
`default_nettype wire

[rtl/thermistor_divider_ema_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_divider_ema_filter
// divider resistance r = ref*(4095-s)*256/s in q.8 ohms, then a per-channel
// moving average avg += (alpha*(r-avg)) >>> 16, all in 4-bit digit steps
// and a one-bit-per-cycle restoring divider
// ----------------------------------------------------------------------------
// sequence: a valid sample steps through 3 multiply digits, 40 divide
//   bits, 6 weighting steps and a finish step; a rail sample or an unused
//   channel goes straight to the finish step, which waits for a free output
// flow: a new item is taken only while the sequencer is idle; the next
//   item is taken while the previous result waits in the output register
// reset: synchronous active-low rst_n clears the averages, control and
//   restores reference_ohms 30000 and smoothing_q16 6554
// ----------------------------------------------------------------------------
module thermistor_divider_ema_filter #(
  parameter int CHANNELS = tdema_pkg::DEF_CHANNELS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [tdema_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [tdema_pkg::CFG_DATA_W-1:0]    cfg_data,
  tdema_in_if.sink                           in_port,
  tdema_out_if.source                        out_port
);

  localparam int SW = tdema_pkg::SAMPLE_W;
  localparam int RW = tdema_pkg::REF_W;
  localparam int AW = tdema_pkg::ALPHA_W;
  localparam int PW = tdema_pkg::PROD_W;
  localparam int QW = tdema_pkg::DIV_STEPS;
  localparam int DW = tdema_pkg::DIGIT_W;
  localparam int VW = tdema_pkg::AVG_W;
  localparam int FW = tdema_pkg::DIFF_W;
  localparam int CW = tdema_pkg::ACC_W;
  localparam int PDW = FW + DW + 1;
  localparam int NW = tdema_pkg::CNT_W;
  localparam int XW = tdema_pkg::APAD_W;

  tdema_pkg::state_t state_r;

  logic [RW-1:0]                   ref_r;
  logic [AW-1:0]                   alpha_r;
  logic [VW-1:0]                   store_r [CHANNELS];

  logic [tdema_pkg::CHANNEL_W-1:0] ch_r;
  logic [SW-1:0]                   s_r;
  logic [SW-1:0]                   m_r;
  logic                            upd_r;
  logic                            oob_r;
  logic [NW-1:0]                   cnt_r;
  logic [PW-1:0]                   prod_r;
  logic [QW-1:0]                   quo_r;
  logic [SW-1:0]                   rem_r;
  logic [XW-1:0]                   a_r;
  logic signed [FW-1:0]            diff_r;
  logic signed [CW-1:0]            acc_r;

  logic                            out_valid_r;
  logic [tdema_pkg::RES_W-1:0]     out_res_r;
  logic                            out_upd_r;

  logic [VW-1:0]                   old_val;
  logic                            in_take;
  logic                            in_oob;
  logic                            in_rail;
  logic [PW-1:0]                   prod_nxt;
  logic [SW:0]                     rem_sh;
  logic                            rem_ge;
  logic [AW-1:0]                   a_sat;
  logic signed [PDW-1:0]           part_d;
  logic signed [CW-1:0]            acc_nxt;
  logic signed [FW:0]              avg_sum;
  logic [VW-1:0]                   avg_val;
  logic                            out_free;
  logic                            fin_load;

  // channel average selection
  always_comb begin
    old_val = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (32'(ch_r) == 32'(k)) begin
        old_val = store_r[k];
      end
    end
  end

  assign in_port.ready = (state_r == tdema_pkg::S_IDLE);
  assign in_take       = in_port.valid && in_port.ready;
  assign in_oob        = (32'(in_port.channel) >= 32'(CHANNELS));
  assign in_rail       = (in_port.sample == '0) || (in_port.sample == tdema_pkg::FULL_SCALE);

  // datapath steps
  assign prod_nxt = {prod_r[PW-DW-1:0], {DW{1'b0}}}
                  + ({{(PW-RW){1'b0}}, ref_r} * {{(PW-DW){1'b0}}, m_r[SW-1 -: DW]});
  assign rem_sh   = {rem_r, quo_r[QW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, s_r});
  assign a_sat    = (alpha_r > tdema_pkg::WEIGHT_ONE) ? tdema_pkg::WEIGHT_ONE : alpha_r;
  assign part_d   = diff_r * $signed({1'b0, a_r[XW-1 -: DW]});
  assign acc_nxt  = (acc_r <<< DW) + {{(CW-PDW){part_d[PDW-1]}}, part_d};
  assign avg_sum  = $signed({2'b00, old_val}) + $signed(acc_r[16 +: FW+1]);
  assign avg_val  = avg_sum[VW-1:0];

  assign out_free = !out_valid_r || out_port.ready;
  assign fin_load = (state_r == tdema_pkg::S_FIN) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= tdema_pkg::REF_RESET;
      alpha_r <= tdema_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdema_pkg::REG_REFERENCE: ref_r   <= cfg_data[RW-1:0];
        tdema_pkg::REG_SMOOTHING: alpha_r <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdema_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        tdema_pkg::S_IDLE: begin
          cnt_r <= '0;
          if (in_take) begin
            state_r <= (in_oob || in_rail) ? tdema_pkg::S_FIN : tdema_pkg::S_MUL;
          end
        end
        tdema_pkg::S_MUL: begin
          if (cnt_r == NW'(tdema_pkg::MUL_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= tdema_pkg::S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        tdema_pkg::S_DIV: begin
          if (cnt_r == NW'(tdema_pkg::DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= tdema_pkg::S_EMA;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        tdema_pkg::S_EMA: begin
          if (cnt_r == NW'(tdema_pkg::EMA_STEPS)) begin
            cnt_r   <= '0;
            state_r <= tdema_pkg::S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        tdema_pkg::S_FIN: begin
          if (out_free) begin
            state_r <= tdema_pkg::S_IDLE;
          end
        end
        default: state_r <= tdema_pkg::S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_port.channel;
      s_r    <= in_port.sample;
      m_r    <= tdema_pkg::FULL_SCALE - in_port.sample;
      upd_r  <= !in_oob && !in_rail;
      oob_r  <= in_oob;
      prod_r <= '0;
    end
    if (state_r == tdema_pkg::S_MUL) begin
      prod_r <= prod_nxt;
      m_r    <= {m_r[SW-DW-1:0], {DW{1'b0}}};
      if (cnt_r == NW'(tdema_pkg::MUL_STEPS - 1)) begin
        quo_r <= {prod_nxt, {tdema_pkg::FRAC_W{1'b0}}};
        rem_r <= '0;
      end
    end
    if (state_r == tdema_pkg::S_DIV) begin
      rem_r <= rem_ge ? SW'(rem_sh - {1'b0, s_r}) : rem_sh[SW-1:0];
      quo_r <= {quo_r[QW-2:0], rem_ge};
    end
    if (state_r == tdema_pkg::S_EMA) begin
      if (cnt_r == '0) begin
        diff_r <= $signed({2'b00, quo_r}) - $signed({1'b0, old_val});
        a_r    <= {{(XW-AW){1'b0}}, a_sat};
        acc_r  <= '0;
      end else begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[XW-DW-1:0], {DW{1'b0}}};
      end
    end
  end

  // channel averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        store_r[k] <= '0;
      end
    end else if (fin_load && upd_r) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (32'(ch_r) == 32'(k)) begin
          store_r[k] <= avg_val;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_upd_r <= upd_r;
      if (upd_r) begin
        out_res_r <= avg_val[tdema_pkg::RES_W-1:0];
      end else if (oob_r) begin
        out_res_r <= '0;
      end else begin
        out_res_r <= old_val[tdema_pkg::RES_W-1:0];
      end
    end
  end

  assign out_port.valid               = out_valid_r;
  assign out_port.filtered_resistance = out_res_r;
  assign out_port.updated             = out_upd_r;

  // checks
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tdema_pkg::S_FIN))
    else $error("result raised outside finish step");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdema_pkg::S_DIV) |-> (rem_r < s_r))
    else $error("divider remainder not below divisor");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != tdema_pkg::S_IDLE))
    else $error("item taken but sequencer stayed idle");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_load && upd_r) |-> !avg_val[VW-1])
    else $error("average exceeds resistance range");

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// checks the thermistor divider filter against a cycle-free predictor of the
// per-channel q.8 resistance average; directed rail and extreme samples, then
// random phases with changing reference and weight, random idling on both
// sides and one long result hold-off that backs up the sample channel
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [tdema_pkg::REF_W-1:0] REF_MAX = '1;
  localparam logic [tdema_pkg::ALPHA_W-1:0] ALPHA_MAX = '1;

  typedef struct packed {
    logic [tdema_pkg::RES_W-1:0] resistance;
    logic                        updated;
  } average_t;

  class average_scoreboard;
    logic [tdema_pkg::AVG_W-1:0]   averages [tdema_pkg::DEF_CHANNELS];
    logic [tdema_pkg::REF_W-1:0]   reference_ohms;
    logic [tdema_pkg::ALPHA_W-1:0] smoothing;
    average_t                      expected_averages [$];
    int                            errors;
    int                            checked;

    function new();
      foreach (averages[k]) averages[k] = '0;
      reference_ohms = tdema_pkg::REF_RESET;
      smoothing = tdema_pkg::ALPHA_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(logic [tdema_pkg::CFG_IDX_W-1:0] index,
                               logic [tdema_pkg::CFG_DATA_W-1:0] data);
      case (index)
        tdema_pkg::REG_REFERENCE: reference_ohms = data[tdema_pkg::REF_W-1:0];
        tdema_pkg::REG_SMOOTHING: smoothing = data[tdema_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [tdema_pkg::CHANNEL_W-1:0] channel,
                              logic [tdema_pkg::SAMPLE_W-1:0] sample);
      logic [63:0] s;
      logic [63:0] r;
      logic [63:0] a;
      logic [63:0] avg;
      average_t    want;
      s = 64'(sample);
      if (int'(channel) >= tdema_pkg::DEF_CHANNELS) begin
        want.resistance = '0;
        want.updated = 1'b0;
      end else if (sample == '0 || sample >= tdema_pkg::FULL_SCALE) begin
        want.resistance = averages[channel][tdema_pkg::RES_W-1:0];
        want.updated = 1'b0;
      end else begin
        r = ((64'(reference_ohms) * (64'(tdema_pkg::FULL_SCALE) - s))
             << tdema_pkg::FRAC_W) / s;
        a = (smoothing > tdema_pkg::WEIGHT_ONE) ? 64'(tdema_pkg::WEIGHT_ONE)
                                                : 64'(smoothing);
        avg = (a * r + (64'(tdema_pkg::WEIGHT_ONE) - a) * 64'(averages[channel])) >> 16;
        averages[channel] = avg[tdema_pkg::AVG_W-1:0];
        want.resistance = avg[tdema_pkg::RES_W-1:0];
        want.updated = 1'b1;
      end
      expected_averages.push_back(want);
    endfunction

    function void check_average(logic [tdema_pkg::RES_W-1:0] resistance, logic updated);
      average_t want;
      checked++;
      if (expected_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                 resistance, updated);
        return;
      end
      want = expected_averages.pop_front();
      if (resistance !== want.resistance) begin
        errors++;
        $display("%0t: filtered_resistance expected %h actual %h", $time,
                 want.resistance, resistance);
      end
      if (updated !== want.updated) begin
        errors++;
        $display("%0t: updated expected %b actual %b", $time, want.updated, updated);
      end
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [tdema_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tdema_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              quiet = 1'b0;
  int                              cycle_count = 0;

  average_scoreboard board = new();

  tdema_in_if  in_ch ();
  tdema_out_if out_ch ();

  thermistor_divider_ema_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_port   (in_ch),
    .out_port  (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.take_sample(in_ch.channel, in_ch.sample);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_average(out_ch.filtered_resistance, out_ch.updated);
  end

  // result side: random stalls, one long hold-off to back up the sample side
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && board.checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic offer_sample(input logic [tdema_pkg::CHANNEL_W-1:0] channel,
                              input logic [tdema_pkg::SAMPLE_W-1:0] sample);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.channel <= channel;
    in_ch.sample <= sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [tdema_pkg::REF_W-1:0] ref_value,
                             input logic [tdema_pkg::ALPHA_W-1:0] alpha_value);
    cfg_we <= 1'b1;
    cfg_index <= tdema_pkg::REG_REFERENCE;
    cfg_data <= tdema_pkg::CFG_DATA_W'(ref_value);
    @(posedge clk);
    board.set_register(tdema_pkg::REG_REFERENCE, tdema_pkg::CFG_DATA_W'(ref_value));
    cfg_index <= tdema_pkg::REG_SMOOTHING;
    cfg_data <= tdema_pkg::CFG_DATA_W'(alpha_value);
    @(posedge clk);
    board.set_register(tdema_pkg::REG_SMOOTHING, tdema_pkg::CFG_DATA_W'(alpha_value));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [tdema_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? tdema_pkg::FULL_SCALE : '0;
      1: return tdema_pkg::SAMPLE_W'($urandom_range(1, 16));
      2: return tdema_pkg::SAMPLE_W'($urandom_range(4080, 4094));
      default: return tdema_pkg::SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [tdema_pkg::REF_W-1:0] pick_reference();
    case ($urandom_range(0, 4))
      0: return REF_MAX;
      1: return tdema_pkg::REF_W'(1);
      2: return tdema_pkg::REF_W'($urandom_range(1, 200));
      3: return tdema_pkg::REF_W'($urandom_range(10000, 100000));
      default: return tdema_pkg::REF_W'($urandom_range(0, 1048575));
    endcase
  endfunction

  function automatic logic [tdema_pkg::ALPHA_W-1:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return tdema_pkg::WEIGHT_ONE;
      1: return '0;
      2: return tdema_pkg::ALPHA_W'($urandom_range(65537, 131071));
      3: return tdema_pkg::ALPHA_W'($urandom_range(1, 2000));
      default: return tdema_pkg::ALPHA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int phase;
    int k;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= tdema_pkg::REG_REFERENCE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.channel <= '0;
    in_ch.sample <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, rails on a cleared store
    offer_sample(1'b0, '0);
    offer_sample(1'b0, tdema_pkg::FULL_SCALE);
    offer_sample(1'b0, 12'd2048);
    offer_sample(1'b0, 12'd1);
    offer_sample(1'b0, 12'd4094);
    offer_sample(1'b0, 12'hAAA);
    offer_sample(1'b1, 12'h555);
    offer_sample(1'b1, tdema_pkg::FULL_SCALE);
    offer_sample(1'b1, '0);
    settle();

    // largest resistance, full weight
    load_config(REF_MAX, tdema_pkg::WEIGHT_ONE);
    offer_sample(1'b0, 12'd1);
    offer_sample(1'b1, 12'd4094);
    offer_sample(1'b0, tdema_pkg::FULL_SCALE);
    settle();

    // zero reference with saturated weight
    load_config('0, ALPHA_MAX);
    offer_sample(1'b0, 12'd100);
    offer_sample(1'b1, 12'd3000);
    settle();

    // zero weight holds the average
    load_config(tdema_pkg::REF_W'(1), '0);
    offer_sample(1'b0, 12'd1);
    offer_sample(1'b1, 12'd2);
    settle();

    load_config(REF_MAX, tdema_pkg::ALPHA_W'(1));
    offer_sample(1'b0, 12'd1);
    offer_sample(1'b1, 12'd1);
    offer_sample(1'b0, tdema_pkg::FULL_SCALE);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      load_config(pick_reference(), pick_weight());
      if (phase == PHASES - 1)
        quiet = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        offer_sample(tdema_pkg::CHANNEL_W'($urandom_range(0, 1)), pick_sample());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
